/* hw/rtl/pgfb_pkg.sv */
// Package for the page frame buffer with refresh stream.
// Holds the transfer payload types, default geometry and command byte constants.
// Depends on nothing.
package pgfb_pkg;

    localparam int WIDTH_DEF  = 132;
    localparam int HEIGHT_DEF = 64;

    localparam logic [7:0] CMD_PAGE     = 8'hB0;
    localparam logic [7:0] CMD_COL_LOW  = 8'h00;
    localparam logic [7:0] CMD_COL_HIGH = 8'h10;

    typedef struct packed {
        logic       action;
        logic [7:0] x;
        logic [7:0] y;
        logic       color;
    } t_pgfb_in;

    typedef struct packed {
        logic       status;
        logic       byte_valid;
        logic [7:0] byte_out;
        logic       is_data;
        logic       frame_last;
    } t_pgfb_out;

endpackage

/* hw/rtl/pgfb_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// Used for the frame store; depends on nothing.
module pgfb_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1056,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/page_framebuffer_with_refresh.sv */
// Page-organized monochrome frame buffer with a byte-serial refresh stream.
// Each transfer reads the frame store, then registers the result and writes back a
// drawn byte; the second step waits while the output is stalled, and no new item is
// taken until the last is through. After reset the store is cleared one byte per cycle,
// all PAGES * WIDTH bytes (1056 at the default geometry), before any input is taken.
// Depends on pgfb_pkg and pgfb_ram.
module page_framebuffer_with_refresh #(
    parameter int WIDTH  = pgfb_pkg::WIDTH_DEF,
    parameter int HEIGHT = pgfb_pkg::HEIGHT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pgfb_pkg::t_pgfb_in  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pgfb_pkg::t_pgfb_out o_out
);

    localparam int PAGES = (HEIGHT + 7) / 8;
    localparam int DEPTH = PAGES * WIDTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = $clog2(WIDTH + 3);

    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [PW-1:0] LAST_POS  = PW'(WIDTH + 2);
    localparam logic [2:0]    LAST_PAGE = 3'(PAGES - 1);
    localparam logic [8:0]    WIDTH_9   = 9'(WIDTH);
    localparam logic [8:0]    HEIGHT_9  = 9'(HEIGHT);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_READ  = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_clr_addr, n_clr_addr;
    logic [2:0]          r_page, n_page;
    logic [PW-1:0]       r_pos, n_pos;
    logic [AW-1:0]       r_ref_addr, n_ref_addr;

    logic                r_draw, n_draw;
    logic                r_oob, n_oob;
    logic                r_color, n_color;
    logic [2:0]          r_bit, n_bit;
    logic [AW-1:0]       r_addr, n_addr;
    logic [7:0]          r_cmd, n_cmd;
    logic                r_is_data, n_is_data;
    logic                r_last, n_last;

    logic                r_out_valid, n_out_valid;
    pgfb_pkg::t_pgfb_out r_out, n_out;

    logic                in_xfer;
    logic                finish;
    logic                oob;
    logic [AW-1:0]       draw_addr;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [7:0]          ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [7:0]          ram_rdata;
    logic [7:0]          mask;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign finish      = (r_state == ST_READ) && (!r_out_valid || !i_out_stall);
    assign oob         = ({1'b0, i_in.x} >= WIDTH_9) || ({1'b0, i_in.y} >= HEIGHT_9);
    assign draw_addr   = AW'(AW'(i_in.y[5:3]) * AW'(WIDTH) + AW'(i_in.x));
    assign mask        = 8'(1) << r_bit;

    assign ram_re      = in_xfer;
    assign ram_raddr   = i_in.action ? r_ref_addr : draw_addr;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = r_color ? (ram_rdata | mask) : (ram_rdata & ~mask);
        if (r_state == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else if (finish && r_draw && !r_oob) begin
            ram_we = 1'b1;
        end
    end

    pgfb_ram #(
        .DATA_W (8),
        .DEPTH  (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_page      = r_page;
        n_pos       = r_pos;
        n_ref_addr  = r_ref_addr;
        n_draw      = r_draw;
        n_oob       = r_oob;
        n_color     = r_color;
        n_bit       = r_bit;
        n_addr      = r_addr;
        n_cmd       = r_cmd;
        n_is_data   = r_is_data;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state   = ST_READ;
                    n_draw    = !i_in.action;
                    n_oob     = oob;
                    n_color   = i_in.color;
                    n_bit     = i_in.y[2:0];
                    n_addr    = draw_addr;
                    n_is_data = 1'b0;
                    n_last    = 1'b0;
                    if (i_in.action) begin
                        case (r_pos)
                            PW'(0):  n_cmd = pgfb_pkg::CMD_PAGE + {5'b0, r_page};
                            PW'(1):  n_cmd = pgfb_pkg::CMD_COL_LOW;
                            PW'(2):  n_cmd = pgfb_pkg::CMD_COL_HIGH;
                            default: n_cmd = '0;
                        endcase
                        if (r_pos > PW'(2)) begin
                            n_is_data = 1'b1;
                            n_last    = (r_pos == LAST_POS) && (r_page == LAST_PAGE);
                            n_ref_addr = (r_ref_addr == LAST_ADDR) ? '0
                                                                   : r_ref_addr + AW'(1);
                        end
                        if (r_pos == LAST_POS) begin
                            n_pos  = '0;
                            n_page = (r_page == LAST_PAGE) ? 3'd0 : r_page + 3'd1;
                        end else begin
                            n_pos = r_pos + PW'(1);
                        end
                    end
                end
            end
            ST_READ: begin
                if (finish) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    if (r_draw) begin
                        n_out = '{status: r_oob, byte_valid: 1'b0, byte_out: 8'h00,
                                  is_data: 1'b0, frame_last: 1'b0};
                    end else begin
                        n_out = '{status: 1'b0, byte_valid: 1'b1,
                                  byte_out: r_is_data ? ram_rdata : r_cmd,
                                  is_data: r_is_data, frame_last: r_last};
                    end
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_page      <= '0;
            r_pos       <= '0;
            r_ref_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_page      <= n_page;
            r_pos       <= n_pos;
            r_ref_addr  <= n_ref_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_draw    <= n_draw;
        r_oob     <= n_oob;
        r_color   <= n_color;
        r_bit     <= n_bit;
        r_addr    <= n_addr;
        r_cmd     <= n_cmd;
        r_is_data <= n_is_data;
        r_last    <= n_last;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* tb/tb_page_framebuffer_with_refresh.sv */
// Self-checking testbench for the page frame buffer: random pixel draws and refresh steps
// are checked against a frame store and stream counters kept in the testbench.
// Depends on pgfb_pkg and the page_framebuffer_with_refresh RTL.
module tb_page_framebuffer_with_refresh;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GW          = pgfb_pkg::WIDTH_DEF;
    localparam int GH          = pgfb_pkg::HEIGHT_DEF;
    localparam int NPAGES      = (GH + 7) / 8;
    localparam int HDR_LEN     = 3;
    localparam int STUCK_LIMIT = 4000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    pgfb_pkg::t_pgfb_in  i_in;
    logic                o_out_valid;
    logic                i_out_stall;
    pgfb_pkg::t_pgfb_out o_out;

    page_framebuffer_with_refresh dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    pgfb_pkg::t_pgfb_in  panel_ops_pending[$];
    pgfb_pkg::t_pgfb_out panel_results_due[$];
    logic [7:0]          pixel_bytes[NPAGES * GW];
    int unsigned         scan_page;
    int unsigned         scan_pos;
    int unsigned         mismatches;
    int unsigned         stuck_cycles;
    int unsigned         in_gap;
    int unsigned         out_hold;
    bit                  in_taken;
    bit                  calm;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int unsigned draw_gap();
        if ($urandom_range(0, 63) == 0) begin
            calm = !calm;
        end
        if (calm) begin
            return 0;
        end
        return $urandom_range(0, 15);
    endfunction

    function automatic pgfb_pkg::t_pgfb_out predict_panel_result(input pgfb_pkg::t_pgfb_in op);
        pgfb_pkg::t_pgfb_out res;
        int unsigned         idx;
        int unsigned         col;
        res = '0;
        if (op.action) begin
            if (scan_page >= NPAGES || scan_pos >= HDR_LEN + GW) begin
                scan_page = 0;
                scan_pos  = 0;
            end
            res.byte_valid = 1'b1;
            if (scan_pos == 0) begin
                res.byte_out = pgfb_pkg::CMD_PAGE + 8'(scan_page);
            end else if (scan_pos == 1) begin
                res.byte_out = pgfb_pkg::CMD_COL_LOW;
            end else if (scan_pos == 2) begin
                res.byte_out = pgfb_pkg::CMD_COL_HIGH;
            end else begin
                col = scan_pos - HDR_LEN;
                idx = scan_page * GW + col;
                res.byte_out   = pixel_bytes[idx];
                res.is_data    = 1'b1;
                res.frame_last = (col + 1 == GW) && (scan_page + 1 == NPAGES);
            end
            scan_pos++;
            if (scan_pos >= HDR_LEN + GW) begin
                scan_pos = 0;
                scan_page++;
                if (scan_page >= NPAGES) begin
                    scan_page = 0;
                end
            end
        end else if (op.x >= GW || op.y >= GH) begin
            res.status = 1'b1;
        end else begin
            idx = op.x + (op.y / 8) * GW;
            pixel_bytes[idx][op.y[2:0]] = op.color;
        end
        return res;
    endfunction

    task automatic queue_op(input bit action, input int x, input int y, input bit color);
        pgfb_pkg::t_pgfb_in op;
        op.action = action;
        op.x      = 8'(x);
        op.y      = 8'(y);
        op.color  = color;
        panel_ops_pending.push_back(op);
    endtask

    // Input side: hold the payload until its transfer, then wait the drawn gap.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_taken) begin
        end else if (in_gap > 0) begin
            i_in_valid <= 1'b0;
            in_gap--;
        end else if (panel_ops_pending.size() > 0) begin
            i_in       <= panel_ops_pending.pop_front();
            i_in_valid <= 1'b1;
            in_gap     = draw_gap();
        end else begin
            i_in_valid <= 1'b0;
        end
        in_taken = 1'b0;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (out_hold > 0) begin
            i_out_stall <= 1'b1;
            out_hold--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        pgfb_pkg::t_pgfb_out want;
        bit                  moved;
        moved = 1'b0;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            panel_results_due.push_back(predict_panel_result(i_in));
            in_taken = 1'b1;
            moved    = 1'b1;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            moved    = 1'b1;
            out_hold = draw_gap();
            if (panel_results_due.size() == 0) begin
                mismatches++;
                $display("%0t: result with none expected, actual %p", $time, o_out);
            end else begin
                want = panel_results_due.pop_front();
                if (o_out.status !== want.status || o_out.byte_valid !== want.byte_valid ||
                        o_out.byte_out !== want.byte_out || o_out.is_data !== want.is_data ||
                        o_out.frame_last !== want.frame_last) begin
                    mismatches++;
                    $display("%0t: mismatch, expected %p, actual %p", $time, want, o_out);
                end
            end
        end
        if (moved) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int unsigned n_items;
        bit          act;
        int          px;
        int          py;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in         = '0;
        i_out_stall  = 1'b0;
        mismatches   = 0;
        stuck_cycles = 0;
        in_gap       = 0;
        out_hold     = 0;
        in_taken     = 1'b0;
        calm         = 1'b0;
        scan_page    = 0;
        scan_pos     = 0;
        foreach (pixel_bytes[i]) begin
            pixel_bytes[i] = 8'h00;
        end

        queue_op(1, 0, 0, 0);
        queue_op(1, 255, 255, 1);
        queue_op(1, 17, 200, 0);
        queue_op(0, 0, 0, 1);
        queue_op(0, GW - 1, GH - 1, 1);
        queue_op(0, GW - 1, 0, 1);
        queue_op(0, 0, GH - 1, 1);
        queue_op(0, 1, 7, 1);
        queue_op(0, 1, 6, 1);
        queue_op(0, 1, 7, 0);
        queue_op(0, 2, 5, 1);
        queue_op(0, GW, 0, 1);
        queue_op(0, 0, GH, 1);
        queue_op(0, 255, 255, 0);
        queue_op(0, GW, GH - 1, 1);
        queue_op(0, 128, 128, 1);
        queue_op(1, 0, 0, 1);
        queue_op(1, 255, 0, 0);
        queue_op(1, 0, 255, 1);
        queue_op(0, 0, 0, 0);
        queue_op(1, 0, 0, 0);

        // A random mix of draws and refresh steps, mostly refresh steps.
        n_items = 0;
        while (n_items < 930) begin
            act = ($urandom_range(0, 3) != 0);
            px  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, GW - 1);
            py  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, GH - 1);
            queue_op(act, px, py, $urandom_range(0, 1));
            n_items++;
        end

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (panel_ops_pending.size() != 0 || i_in_valid || panel_results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
